// ----- src/mandelbrot_escape_time_pixel_defines.svh -----
// assertion helpers shared by the block
`ifndef MANDELBROT_ESCAPE_TIME_PIXEL_DEFINES_SVH
`define MANDELBROT_ESCAPE_TIME_PIXEL_DEFINES_SVH

// property must hold at every edge outside reset
`define MET_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be seen outside reset
`define MET_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- src/met_pkg.sv -----
`default_nettype none

package met_pkg;

  // fixed point format q4.28
  localparam int unsigned FracBits = 28;

  // configuration port
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ORIGIN_RE  = 3'd0,
    REG_ORIGIN_IM  = 3'd1,
    REG_PIXEL_STEP = 3'd2,
    REG_MAX_ITER   = 3'd3,
    REG_COLOR_STEP = 3'd4
  } cfg_reg_e;

  // register reset values
  localparam logic signed [31:0] OriginReRst  = -32'sd550292685;
  localparam logic signed [31:0] OriginImRst  = -32'sd348966093;
  localparam logic [30:0]        PixelStepRst = 31'd894784;
  localparam logic [15:0]        MaxIterRst   = 16'd50;
  localparam logic [23:0]        ColorStepRst = 24'd265;

  // escape bound 4.0 in q8.56
  localparam logic [63:0] EscapeBound = 64'h0400_0000_0000_0000;

  // queue between front and back, depth a power of two
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  typedef struct packed {
    logic signed [31:0] origin_re;
    logic signed [31:0] origin_im;
    logic [30:0]        pixel_step;
    logic [15:0]        max_iterations;
    logic [23:0]        color_step;
  } cfg_t;

  typedef struct packed {
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
  } pixel_in_t;

  typedef struct packed {
    logic [11:0] out_x;
    logic [11:0] out_y;
    logic [15:0] iterations;
    logic [31:0] pixel_color;
  } result_t;

  // mapped point waiting for the iteration engine
  typedef struct packed {
    logic [11:0]        x;
    logic [11:0]        y;
    logic signed [31:0] cr;
    logic signed [31:0] ci;
  } coord_t;

  typedef struct packed {
    logic full;
    logic not_empty;
  } q_stat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_UPD,
    ST_DONE
  } eng_state_e;

  // clamp to the signed 32 bit range
  function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
    logic signed [31:0] r;
    if (v > 48'sh0000_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < 48'shFFFF_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- src/mandelbrot_escape_time_pixel.sv -----
`default_nettype none

// channel   direction  handshake           payload
// in        input      in_valid / stall    pixel_x, pixel_y
// out       output     out_valid / stall   out_x, out_y, iterations, pixel_color
// cfg       input      cfg_valid / ready   register index, 32 bit data
//
// a pixel passes the front pipe, waits in the queue, then iterates in the back
// until it escapes or reaches the limit; each iteration is one pass through the
// three multipliers (zr*zr, zi*zi, zr*zi) and one pass through the update adders
// two items can wait in the queue while the back iterates
// reset clears all control state and loads the default view
// out_stall holds the result register, the engine and the front back up behind it

module mandelbrot_escape_time_pixel #(
  parameter int unsigned WINDOW_WIDTH  = 1024,
  parameter int unsigned WINDOW_HEIGHT = 1024
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire met_pkg::pixel_in_t            in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output met_pkg::result_t                   out_data_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [met_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [met_pkg::CfgDataW-1:0]  cfg_data_i
);

  met_pkg::cfg_t    cfg_q;
  met_pkg::coord_t  push_data, pop_data;
  met_pkg::q_stat_t q_stat;
  logic             push, pop;

  // register file, writes land at any time
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.origin_re      <= met_pkg::OriginReRst;
      cfg_q.origin_im      <= met_pkg::OriginImRst;
      cfg_q.pixel_step     <= met_pkg::PixelStepRst;
      cfg_q.max_iterations <= met_pkg::MaxIterRst;
      cfg_q.color_step     <= met_pkg::ColorStepRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (met_pkg::cfg_reg_e'(cfg_index_i))
        met_pkg::REG_ORIGIN_RE:  cfg_q.origin_re      <= cfg_data_i;
        met_pkg::REG_ORIGIN_IM:  cfg_q.origin_im      <= cfg_data_i;
        met_pkg::REG_PIXEL_STEP: cfg_q.pixel_step     <= cfg_data_i[30:0];
        met_pkg::REG_MAX_ITER:   cfg_q.max_iterations <= cfg_data_i[15:0];
        met_pkg::REG_COLOR_STEP: cfg_q.color_step     <= cfg_data_i[23:0];
        default: ;
      endcase
    end
  end

  // window check and coordinate mapping
  met_front #(
    .WINDOW_WIDTH  (WINDOW_WIDTH),
    .WINDOW_HEIGHT (WINDOW_HEIGHT)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .push_o      (push),
    .push_data_o (push_data),
    .q_stat_i    (q_stat)
  );

  // decoupling queue
  met_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .q_stat_o    (q_stat)
  );

  // iteration engine and result register
  met_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_stat_i    (q_stat),
    .pop_data_i  (pop_data),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// ----- src/met_front.sv -----
`default_nettype none

module met_front #(
  parameter int unsigned WINDOW_WIDTH  = 1024,
  parameter int unsigned WINDOW_HEIGHT = 1024
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire met_pkg::cfg_t      cfg_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire met_pkg::pixel_in_t in_data_i,
  output logic                    push_o,
  output met_pkg::coord_t         push_data_o,
  input  wire met_pkg::q_stat_t   q_stat_i
);

  logic                 a_valid_q, a_valid_d;
  met_pkg::pixel_in_t   a_pix_q;
  logic                 b_valid_q, b_valid_d;
  logic [11:0]          b_x_q, b_y_q;
  logic [42:0]          b_pr_q, b_pi_q;
  logic                 b_adv, a_free, in_window;
  logic signed [47:0]   sum_re, sum_im;

  // window check, pixels outside are dropped at the transfer
  assign in_window = ({1'b0, in_data_i.pixel_x} < 13'(WINDOW_WIDTH)) &&
                     ({1'b0, in_data_i.pixel_y} < 13'(WINDOW_HEIGHT));

  // two stage pipe with stall propagation
  assign b_adv      = !b_valid_q || !q_stat_i.full;
  assign a_free     = !a_valid_q || b_adv;
  assign in_stall_o = !a_free;

  always_comb begin
    a_valid_d = a_valid_q;
    b_valid_d = b_valid_q;
    if (a_free) begin
      a_valid_d = in_valid_i && in_window;
    end
    if (b_adv) begin
      b_valid_d = a_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      a_valid_q <= a_valid_d;
      b_valid_q <= b_valid_d;
    end
  end

  // payload: latch pixel, then form pixel times step
  always_ff @(posedge clk_i) begin
    if (a_free) begin
      a_pix_q <= in_data_i;
    end
    if (b_adv) begin
      b_x_q  <= a_pix_q.pixel_x;
      b_y_q  <= a_pix_q.pixel_y;
      b_pr_q <= {31'd0, a_pix_q.pixel_x} * {12'd0, cfg_i.pixel_step};
      b_pi_q <= {31'd0, a_pix_q.pixel_y} * {12'd0, cfg_i.pixel_step};
    end
  end

  // add the view corner and clamp
  assign sum_re = $signed({5'd0, b_pr_q}) +
                  $signed({{16{cfg_i.origin_re[31]}}, cfg_i.origin_re});
  assign sum_im = $signed({5'd0, b_pi_q}) +
                  $signed({{16{cfg_i.origin_im[31]}}, cfg_i.origin_im});

  assign push_o         = b_valid_q && !q_stat_i.full;
  assign push_data_o.x  = b_x_q;
  assign push_data_o.y  = b_y_q;
  assign push_data_o.cr = met_pkg::sat32(sum_re);
  assign push_data_o.ci = met_pkg::sat32(sum_im);

endmodule

`default_nettype wire

// ----- src/met_queue.sv -----
`default_nettype none

module met_queue (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire met_pkg::coord_t  push_data_i,
  input  wire logic             pop_i,
  output met_pkg::coord_t       pop_data_o,
  output met_pkg::q_stat_t      q_stat_o
);

  met_pkg::coord_t                entry_q [met_pkg::QDepth];
  logic [met_pkg::QPtrW-1:0]      wr_ptr_q, rd_ptr_q;
  logic [met_pkg::QCntW-1:0]      cnt_q, cnt_d;

  // occupancy
  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign pop_data_o         = entry_q[rd_ptr_q];
  assign q_stat_o.full      = (cnt_q == met_pkg::QCntW'(met_pkg::QDepth));
  assign q_stat_o.not_empty = (cnt_q != '0);

endmodule

`default_nettype wire

// ----- src/met_back.sv -----
`default_nettype none
`include "mandelbrot_escape_time_pixel_defines.svh"

module met_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire met_pkg::cfg_t    cfg_i,
  input  wire met_pkg::q_stat_t q_stat_i,
  input  wire met_pkg::coord_t  pop_data_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output met_pkg::result_t      out_data_o
);

  met_pkg::eng_state_e state_q, state_d;

  logic signed [31:0] zr_q, zi_q, cr_q, ci_q;
  logic [11:0]        x_q, y_q;
  logic [15:0]        count_q;
  logic signed [63:0] sr_q, si_q, cross_q;
  logic               out_valid_q;
  met_pkg::result_t   res_q;

  logic               out_free, finish, load_out, step;
  logic [63:0]        mag;
  logic signed [63:0] diff;
  logic signed [47:0] sum_r, sum_i;
  logic [39:0]        color_prod;

  // escape test and z update from the registered products
  assign mag    = sr_q + si_q;
  assign finish = !(mag < met_pkg::EscapeBound) || (count_q >= cfg_i.max_iterations);
  assign diff   = sr_q - si_q;
  assign sum_r  = $signed({{12{diff[63]}}, diff[63:28]}) +
                  $signed({{16{cr_q[31]}}, cr_q});
  assign sum_i  = $signed({{11{cross_q[63]}}, cross_q[63:27]}) +
                  $signed({{16{ci_q[31]}}, ci_q});

  assign out_free   = !out_valid_q || !out_stall_i;
  assign color_prod = {16'd0, cfg_i.color_step} * {24'd0, count_q};

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      met_pkg::ST_IDLE: begin
        if (q_stat_i.not_empty) begin
          state_d = met_pkg::ST_MUL;
        end
      end
      met_pkg::ST_MUL: begin
        state_d = met_pkg::ST_UPD;
      end
      met_pkg::ST_UPD: begin
        state_d = finish ? met_pkg::ST_DONE : met_pkg::ST_MUL;
      end
      met_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = met_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = met_pkg::ST_IDLE;
      end
    endcase
  end

  // control outputs
  always_comb begin
    pop_o    = 1'b0;
    step     = 1'b0;
    load_out = 1'b0;
    unique case (state_q)
      met_pkg::ST_IDLE: pop_o    = q_stat_i.not_empty;
      met_pkg::ST_UPD:  step     = !finish;
      met_pkg::ST_DONE: load_out = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= met_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      count_q     <= '0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (pop_o) begin
        count_q <= '0;
      end else if (step) begin
        count_q <= count_q + 16'd1;
      end
    end
  end

  // iteration datapath
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      zr_q <= '0;
      zi_q <= '0;
      cr_q <= pop_data_i.cr;
      ci_q <= pop_data_i.ci;
      x_q  <= pop_data_i.x;
      y_q  <= pop_data_i.y;
    end else if (step) begin
      zr_q <= met_pkg::sat32(sum_r);
      zi_q <= met_pkg::sat32(sum_i);
    end
    if (state_q == met_pkg::ST_MUL) begin
      sr_q    <= zr_q * zr_q;
      si_q    <= zi_q * zi_q;
      cross_q <= zr_q * zi_q;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      res_q.out_x       <= x_q;
      res_q.out_y       <= y_q;
      res_q.iterations  <= count_q;
      res_q.pixel_color <= (count_q == cfg_i.max_iterations) ? 32'd0 : color_prod[31:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = res_q;

  `MET_ASSERT(a_count_bounded, clk_i, rst_ni, (state_q != met_pkg::ST_IDLE) |-> (count_q <= cfg_i.max_iterations), "iteration count passed the limit")
  `MET_ASSERT(a_count_steps, clk_i, rst_ni, (state_q == met_pkg::ST_UPD && state_d == met_pkg::ST_MUL) |=> (count_q == $past(count_q) + 16'd1), "count did not advance with an iteration")
  `MET_ASSERT(a_limit_black, clk_i, rst_ni, (out_valid_q && res_q.iterations == cfg_i.max_iterations) |-> (res_q.pixel_color == 32'd0), "pixel at the limit is not black")

endmodule

`default_nettype wire

// ----- bench/tb_mandelbrot_escape_time_pixel.sv -----
`default_nettype none

module tb_mandelbrot_escape_time_pixel;

  localparam int unsigned WinWidth     = 1024;
  localparam int unsigned WinHeight    = 1024;
  localparam int unsigned CycleLimit   = 2000000;
  localparam int unsigned DrainPause   = 40;
  localparam int unsigned ItemsPerView = 100;
  localparam int unsigned MaxReports   = 10;

  // expected escape results, predicted from the current view registers
  class escape_scoreboard;
    met_pkg::cfg_t    view;
    met_pkg::result_t pending_results[$];
    int unsigned      mismatches;
    int unsigned      accepted;
    int unsigned      checked;

    function new();
      view = '{origin_re: met_pkg::OriginReRst, origin_im: met_pkg::OriginImRst,
               pixel_step: met_pkg::PixelStepRst, max_iterations: met_pkg::MaxIterRst,
               color_step: met_pkg::ColorStepRst};
      mismatches = 0;
      accepted = 0;
      checked = 0;
    endfunction

    // register write as the block decodes it
    function void set_reg(logic [met_pkg::CfgIdxW-1:0] idx,
                          logic [met_pkg::CfgDataW-1:0] data);
      case (idx)
        met_pkg::REG_ORIGIN_RE:  view.origin_re = data;
        met_pkg::REG_ORIGIN_IM:  view.origin_im = data;
        met_pkg::REG_PIXEL_STEP: view.pixel_step = data[30:0];
        met_pkg::REG_MAX_ITER:   view.max_iterations = data[15:0];
        met_pkg::REG_COLOR_STEP: view.color_step = data[23:0];
        default: ;
      endcase
    endfunction

    // clamp to the q4.28 range
    function longint clamp_q428(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    // escape-time iteration for one pixel, 0 when outside the window
    function bit predict_escape(met_pkg::pixel_in_t px, output met_pkg::result_t res);
      longint      cr, ci, zr, zi, sr, si, cross_prod;
      logic [63:0] mag;
      logic [63:0] prod;
      int unsigned count;
      res = '0;
      if (px.pixel_x >= WinWidth || px.pixel_y >= WinHeight) return 0;
      cr = clamp_q428(longint'(px.pixel_x) * longint'(view.pixel_step)
                      + longint'($signed(view.origin_re)));
      ci = clamp_q428(longint'(px.pixel_y) * longint'(view.pixel_step)
                      + longint'($signed(view.origin_im)));
      zr = 0;
      zi = 0;
      count = 0;
      forever begin
        sr = zr * zr;
        si = zi * zi;
        mag = $unsigned(sr) + $unsigned(si);
        if (mag >= met_pkg::EscapeBound) break;
        if (count >= view.max_iterations) break;
        cross_prod = zr * zi;
        // floor by arithmetic shift, then add c and clamp
        zr = clamp_q428(((sr - si) >>> met_pkg::FracBits) + cr);
        zi = clamp_q428((cross_prod >>> (met_pkg::FracBits - 1)) + ci);
        count++;
      end
      prod = longint'(view.color_step) * longint'(count);
      res.out_x = px.pixel_x;
      res.out_y = px.pixel_y;
      res.iterations = count[15:0];
      res.pixel_color = (count == view.max_iterations) ? 32'd0 : prod[31:0];
      return 1;
    endfunction

    function void note_pixel(met_pkg::pixel_in_t px);
      met_pkg::result_t res;
      accepted++;
      if (predict_escape(px, res)) pending_results.push_back(res);
    endfunction

    function void compare(string field, longint unsigned want, longint unsigned got);
      if (want != got) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("mismatch %s: expected %0d, got %0d", field, want, got);
      end
    endfunction

    function void check_result(met_pkg::result_t got);
      met_pkg::result_t want;
      checked++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("unexpected result for pixel (%0d, %0d): iterations %0d, color %0d",
                   got.out_x, got.out_y, got.iterations, got.pixel_color);
        return;
      end
      want = pending_results.pop_front();
      compare("out_x", want.out_x, got.out_x);
      compare("out_y", want.out_y, got.out_y);
      compare("iterations", want.iterations, got.iterations);
      compare("pixel_color", want.pixel_color, got.pixel_color);
    endfunction
  endclass

  logic                          clk_i;
  logic                          rst_ni = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  met_pkg::pixel_in_t            in_data = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  met_pkg::result_t              out_data;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [met_pkg::CfgIdxW-1:0]   cfg_index = '0;
  logic [met_pkg::CfgDataW-1:0]  cfg_data = '0;

  escape_scoreboard sb = new();
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned cycle_count = 0;
  int unsigned cfg_writes = 0;
  int unsigned views_loaded = 0;

  mandelbrot_escape_time_pixel #(
    .WINDOW_WIDTH (WinWidth),
    .WINDOW_HEIGHT(WinHeight)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // receiver back-pressure
  always @(posedge clk_i) begin
    out_stall <= (recv_idle_pct != 0) && ($urandom_range(99) < recv_idle_pct);
  end

  // watch both channels for transfers
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && !in_stall) sb.note_pixel(in_data);
      if (out_valid && !out_stall) sb.check_result(out_data);
    end
  end

  // run timeout
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, sb.pending_results.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_pixel(input logic [11:0] x, input logic [11:0] y);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data <= '{pixel_x: x, pixel_y: y};
    do @(posedge clk_i); while (in_stall);
  endtask

  task automatic write_reg(input logic [met_pkg::CfgIdxW-1:0] idx,
                           input logic [met_pkg::CfgDataW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk_i); while (!cfg_ready);
    sb.set_reg(idx, data);
    cfg_writes++;
  endtask

  task automatic end_writes();
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic load_view(input logic [31:0] ore, input logic [31:0] oim,
                           input logic [31:0] step, input logic [31:0] iters,
                           input logic [31:0] color);
    write_reg(met_pkg::REG_ORIGIN_RE, ore);
    write_reg(met_pkg::REG_ORIGIN_IM, oim);
    write_reg(met_pkg::REG_PIXEL_STEP, step);
    write_reg(met_pkg::REG_MAX_ITER, iters);
    write_reg(met_pkg::REG_COLOR_STEP, color);
    end_writes();
    views_loaded++;
  endtask

  // wait for all results, then let out-of-window pixels leave the front
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (sb.pending_results.size() != 0);
    repeat (DrainPause) @(posedge clk_i);
  endtask

  // view around the set with a short iteration limit
  task automatic random_view();
    load_view(-$urandom_range(603979776, 134217728), -$urandom_range(402653184, 67108864),
              $urandom_range(900000, 100000), $urandom_range(60, 1), $urandom());
  endtask

  // mostly in-window pixels, some anywhere in the field range
  task automatic random_burst(input int unsigned n);
    int unsigned sent;
    logic [11:0] x;
    logic [11:0] y;
    sent = 0;
    while (sent < n) begin
      x = ($urandom_range(99) < 85) ? 12'($urandom_range(WinWidth - 1)) : 12'($urandom());
      y = ($urandom_range(99) < 85) ? 12'($urandom_range(WinHeight - 1)) : 12'($urandom());
      send_pixel(x, y);
      sent++;
    end
  endtask

  initial begin
    logic [met_pkg::CfgIdxW-1:0] spare_idx;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle_pct = 9;
    recv_idle_pct = 65;

    // default view: corners, a point inside the set, out-of-window pixels
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd1023, 12'd1023);
    send_pixel(12'd1023, 12'd0);
    send_pixel(12'd0, 12'd1023);
    send_pixel(12'd615, 12'd390);
    send_pixel(12'd1024, 12'd5);
    send_pixel(12'd7, 12'd1024);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'hAAA, 12'h555);
    send_pixel(12'h2AA, 12'h155);
    send_pixel(12'h155, 12'h2AA);
    drain();

    // saturated mapping, zero limit, all-ones data, unused register indexes
    write_reg(met_pkg::REG_ORIGIN_RE, 32'h8000_0000);
    write_reg(met_pkg::REG_ORIGIN_IM, 32'h7FFF_FFFF);
    write_reg(met_pkg::REG_PIXEL_STEP, 32'hFFFF_FFFF);
    write_reg(met_pkg::REG_MAX_ITER, 32'hFFFF_0000);
    write_reg(met_pkg::REG_COLOR_STEP, 32'hFFFF_FFFF);
    for (int i = int'(met_pkg::REG_COLOR_STEP) + 1; i < (1 << met_pkg::CfgIdxW); i++) begin
      spare_idx = i[met_pkg::CfgIdxW-1:0];
      write_reg(spare_idx, $urandom());
    end
    end_writes();
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd1023, 12'd1023);
    send_pixel(12'd512, 12'd3);
    drain();

    // limit of one and two
    write_reg(met_pkg::REG_MAX_ITER, 32'd1);
    end_writes();
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd1023, 12'd1023);
    drain();
    write_reg(met_pkg::REG_MAX_ITER, 32'd2);
    end_writes();
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd1023, 12'd1023);
    drain();

    // full iteration limit at c = 0
    load_view(32'd0, 32'd0, 32'd0, 32'd65535, 32'd1);
    send_pixel(12'd0, 12'd0);
    drain();

    // random views under three idle patterns
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 9 : (phase == 1) ? 65 : 0;
      recv_idle_pct = (phase == 0) ? 65 : (phase == 1) ? 9 : 0;
      repeat (2) begin
        random_view();
        random_burst(ItemsPerView);
        drain();
      end
    end

    $display("pixels accepted %0d, results checked %0d, mismatches %0d",
             sb.accepted, sb.checked, sb.mismatches);
    $display("register writes %0d over %0d full view loads and three idle patterns",
             cfg_writes, views_loaded);
    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
